### rtl/prx_pkg.sv
// Shared types and character constants for the POSIX to ECMAScript regex translator.
`default_nettype none
package prx_pkg;

  localparam logic [7:0] CharBslash = 8'h5C;  // backslash
  localparam logic [7:0] CharLbrack = 8'h5B;  // [
  localparam logic [7:0] CharRbrack = 8'h5D;  // ]
  localparam logic [7:0] CharCaret  = 8'h5E;  // ^
  localparam logic [7:0] CharLparen = 8'h28;
  localparam logic [7:0] CharRparen = 8'h29;
  localparam logic [7:0] CharLbrace = 8'h7B;
  localparam logic [7:0] CharRbrace = 8'h7D;
  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharQmark  = 8'h3F;
  localparam logic [7:0] CharPipe   = 8'h7C;
  localparam logic [7:0] CharLess   = 8'h3C;
  localparam logic [7:0] CharGreat  = 8'h3E;
  localparam logic [7:0] CharB      = 8'h62;  // b
  localparam logic [7:0] CharColon  = 8'h3A;
  localparam logic [7:0] CharDot    = 8'h2E;
  localparam logic [7:0] CharEqual  = 8'h3D;

  localparam logic [1:0] KindColon = 2'd0;
  localparam logic [1:0] KindDot   = 2'd1;
  localparam logic [1:0] KindEqual = 2'd2;

  typedef struct packed {
    logic [7:0] pattern_char;
    logic       pattern_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
  } out_item_t;

  // Result of one input item: up to two bytes, first byte goes out first.
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } xlate_res_t;

  function automatic logic [7:0] kind_char(input logic [1:0] kind);
    logic [7:0] c;
    unique case (kind)
      KindDot:   c = CharDot;
      KindEqual: c = CharEqual;
      default:   c = CharColon;
    endcase
    return c;
  endfunction

  function automatic logic is_group_char(input logic [7:0] c);
    return (c == CharLparen) || (c == CharRparen) || (c == CharLbrace) ||
           (c == CharRbrace) || (c == CharPlus) || (c == CharQmark) ||
           (c == CharPipe);
  endfunction

endpackage
`default_nettype wire

### rtl/posix_regex_to_ecma_translator_unit.sv
// Top level of the POSIX to ECMAScript regex translator.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid / stall   | pattern_char, pattern_last
//   out     | output    | out_valid / stall  | out_char, out_last
//   cfg     | input     | cfg_valid / ready  | extended_mode
//
// A byte is translated in the cycle it is accepted and lands in the result
// register; it goes out from the next cycle on. One-byte results sustain one
// item per cycle while out_stall is low; a two-byte result holds the input
// off until its first byte is out (one output port drains the two entries).
// Reset clears the scanner to normal text and the mode to basic. A stalled
// output holds the input off only once the result register cannot take more.
`default_nettype none
module posix_regex_to_ecma_translator_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire prx_pkg::in_item_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output prx_pkg::out_item_t     out_data_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic              cfg_data_i
);

  logic                extended_q;
  logic                room;
  logic                accept;
  prx_pkg::xlate_res_t res;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !room;
  assign accept      = in_valid_i && room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      extended_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      extended_q <= cfg_data_i;
    end
  end

  prx_xlate u_xlate (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .extended_i (extended_q),
    .accept_i   (accept),
    .item_i     (in_data_i),
    .res_o      (res)
  );

  prx_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .res_i       (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

### rtl/prx_xlate.sv
// Scanner state and per-byte translation into zero to two result bytes.
`default_nettype none
module prx_xlate (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             extended_i,
  input  wire logic             accept_i,
  input  wire prx_pkg::in_item_t item_i,
  output prx_pkg::xlate_res_t   res_o
);

  typedef enum logic [2:0] {
    ScanNormal,
    ScanEscape,
    ScanBrStart,
    ScanBrCaret,
    ScanBrBody,
    ScanBrOpen,
    ScanSub,
    ScanSubEnd
  } scan_e;

  scan_e      scan_q, scan_d;
  logic [1:0] kind_q, kind_d;

  logic [7:0] c;
  logic       last;
  logic [7:0] kc;
  logic [1:0] cnt;
  logic [7:0] b0, b1;
  scan_e      body_nxt;

  always_comb begin
    c    = item_i.pattern_char;
    last = item_i.pattern_last;
    kc   = prx_pkg::kind_char(kind_q);

    if (c == prx_pkg::CharRbrack) begin
      body_nxt = ScanNormal;
    end else if (c == prx_pkg::CharLbrack) begin
      body_nxt = ScanBrOpen;
    end else begin
      body_nxt = ScanBrBody;
    end

    cnt    = 2'd1;
    b0     = c;
    b1     = c;
    scan_d = scan_q;
    kind_d = kind_q;

    unique case (scan_q)
      ScanNormal: begin
        if (c == prx_pkg::CharLbrack) begin
          scan_d = ScanBrStart;
        end else if (c == prx_pkg::CharBslash) begin
          if (!last) begin
            cnt    = 2'd0;
            scan_d = ScanEscape;
          end
        end else if (!extended_i && prx_pkg::is_group_char(c)) begin
          cnt = 2'd2;
          b0  = prx_pkg::CharBslash;
        end
      end
      ScanEscape: begin
        if (c == prx_pkg::CharLess || c == prx_pkg::CharGreat) begin
          cnt = 2'd2;
          b0  = prx_pkg::CharBslash;
          b1  = prx_pkg::CharB;
        end else if (!(!extended_i && prx_pkg::is_group_char(c))) begin
          cnt = 2'd2;
          b0  = prx_pkg::CharBslash;
        end
        scan_d = ScanNormal;
      end
      ScanBrStart: begin
        if (c == prx_pkg::CharCaret) begin
          scan_d = ScanBrCaret;
        end else if (c == prx_pkg::CharRbrack) begin
          scan_d = ScanBrBody;
        end else begin
          scan_d = body_nxt;
        end
      end
      ScanBrCaret: begin
        scan_d = (c == prx_pkg::CharRbrack) ? ScanBrBody : body_nxt;
      end
      ScanBrBody: begin
        scan_d = body_nxt;
      end
      ScanBrOpen: begin
        if (c == prx_pkg::CharColon) begin
          kind_d = prx_pkg::KindColon;
          scan_d = ScanSub;
        end else if (c == prx_pkg::CharDot) begin
          kind_d = prx_pkg::KindDot;
          scan_d = ScanSub;
        end else if (c == prx_pkg::CharEqual) begin
          kind_d = prx_pkg::KindEqual;
          scan_d = ScanSub;
        end else begin
          scan_d = body_nxt;
        end
      end
      ScanSub: begin
        if (c == kc) scan_d = ScanSubEnd;
      end
      ScanSubEnd: begin
        // repeated kind chars keep the close pending
        if (c == prx_pkg::CharRbrack) begin
          scan_d = ScanBrBody;
        end else if (c != kc) begin
          scan_d = ScanSub;
        end
      end
      default: scan_d = ScanNormal;
    endcase

    if (last) scan_d = ScanNormal;

    res_o.count           = cnt;
    res_o.first.out_char  = b0;
    res_o.first.out_last  = last && (cnt == 2'd1);
    res_o.second.out_char = b1;
    res_o.second.out_last = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= ScanNormal;
      kind_q <= prx_pkg::KindColon;
    end else if (accept_i) begin
      scan_q <= scan_d;
      kind_q <= kind_d;
    end
  end

endmodule
`default_nettype wire

### rtl/prx_outbuf.sv
// Two-entry result register that hands translated bytes out one per transfer.
`default_nettype none
module prx_outbuf (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                load_i,
  input  wire prx_pkg::xlate_res_t res_i,
  output logic                     room_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output prx_pkg::out_item_t       out_data_o
);

  logic [1:0]         cnt_q, cnt_d;
  prx_pkg::out_item_t slot0_q, slot0_d;
  prx_pkg::out_item_t slot1_q, slot1_d;
  logic               take;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = slot0_q;
  assign take        = out_valid_o && !out_stall_i;
  // new item fits once the buffer drains this cycle
  assign room_o      = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && take);

  always_comb begin
    cnt_d   = cnt_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (load_i && res_i.count != 2'd0) begin
      cnt_d = res_i.count;
      if (res_i.count == 2'd1) begin
        slot0_d = res_i.second;
      end else begin
        slot0_d = res_i.first;
        slot1_d = res_i.second;
      end
    end else if (take) begin
      cnt_d   = cnt_q - 2'd1;
      slot0_d = slot1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule
`default_nettype wire

### sim/posix_regex_to_ecma_translator_unit_tb.sv
// Testbench for the POSIX to ECMAScript regex translator: directed and random pattern streams checked per byte.
`default_nettype none
module posix_regex_to_ecma_translator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    ScanText, ScanEscape, ScanOpen, ScanCaret, ScanBody, ScanBodyLbrack, ScanSub, ScanSubKind
  } scan_e;

  localparam int MaxReported = 10;
  localparam int DrainCycles = 6;
  localparam int PhaseBytes  = 212;

  class xlate_scoreboard;
    scan_e               scan;
    logic [1:0]          kind;
    logic                extended;
    prx_pkg::out_item_t  expected_q[$];
    int                  errors;
    int                  checked;

    function new();
      scan = ScanText;
      kind = prx_pkg::KindColon;
      extended = 1'b0;
      errors = 0;
      checked = 0;
    endfunction

    function logic is_group_op(logic [7:0] c);
      return c == prx_pkg::CharLparen || c == prx_pkg::CharRparen ||
             c == prx_pkg::CharLbrace || c == prx_pkg::CharRbrace ||
             c == prx_pkg::CharPlus || c == prx_pkg::CharQmark || c == prx_pkg::CharPipe;
    endfunction

    function scan_e body_after(logic [7:0] c);
      if (c == prx_pkg::CharRbrack) return ScanText;
      if (c == prx_pkg::CharLbrack) return ScanBodyLbrack;
      return ScanBody;
    endfunction

    // Translate one accepted pattern byte into zero, one or two expected bytes.
    function void note_input(prx_pkg::in_item_t it);
      logic [7:0] c;
      logic [7:0] kc;
      logic [7:0] b0;
      logic [7:0] b1;
      logic       last;
      int         n;
      c = it.pattern_char;
      last = it.pattern_last;
      kc = (kind == prx_pkg::KindDot)   ? prx_pkg::CharDot :
           (kind == prx_pkg::KindEqual) ? prx_pkg::CharEqual : prx_pkg::CharColon;
      b0 = c;
      b1 = c;
      n = 1;
      case (scan)
        ScanText: begin
          if (c == prx_pkg::CharLbrack) begin
            scan = ScanOpen;
          end else if (c == prx_pkg::CharBslash) begin
            if (!last) begin
              n = 0;
              scan = ScanEscape;
            end
          end else if (!extended && is_group_op(c)) begin
            b0 = prx_pkg::CharBslash;
            n = 2;
          end
        end
        ScanEscape: begin
          if (c == prx_pkg::CharLess || c == prx_pkg::CharGreat) begin
            b0 = prx_pkg::CharBslash;
            b1 = prx_pkg::CharB;
            n = 2;
          end else if (!(!extended && is_group_op(c))) begin
            b0 = prx_pkg::CharBslash;
            n = 2;
          end
          scan = ScanText;
        end
        ScanOpen, ScanCaret: begin
          // a ] right after [ or [^ is a literal member
          if (scan == ScanOpen && c == prx_pkg::CharCaret) scan = ScanCaret;
          else if (c == prx_pkg::CharRbrack) scan = ScanBody;
          else scan = body_after(c);
        end
        ScanBody: scan = body_after(c);
        ScanBodyLbrack: begin
          if (c == prx_pkg::CharColon || c == prx_pkg::CharDot || c == prx_pkg::CharEqual) begin
            kind = (c == prx_pkg::CharColon) ? prx_pkg::KindColon :
                   (c == prx_pkg::CharDot)   ? prx_pkg::KindDot : prx_pkg::KindEqual;
            scan = ScanSub;
          end else begin
            scan = body_after(c);
          end
        end
        ScanSub: if (c == kc) scan = ScanSubKind;
        default: begin
          if (c == prx_pkg::CharRbrack) scan = ScanBody;
          else if (c != kc) scan = ScanSub;
        end
      endcase
      if (last) scan = ScanText;
      if (n >= 1) expected_q.push_back('{out_char: b0, out_last: last && n == 1});
      if (n == 2) expected_q.push_back('{out_char: b1, out_last: last});
    endfunction

    function void check_result(prx_pkg::out_item_t got);
      prx_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MaxReported)
          $display("unexpected output: char %h last %b", got.out_char, got.out_last);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.out_char !== want.out_char || got.out_last !== want.out_last) begin
        errors++;
        if (errors <= MaxReported)
          $display("mismatch at byte %0d: expected char %h last %b, got char %h last %b",
                   checked, want.out_char, want.out_last, got.out_char, got.out_last);
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  prx_pkg::in_item_t  in_data;
  logic               in_stall_o;
  logic               out_valid_o;
  logic               out_stall;
  prx_pkg::out_item_t out_data_o;
  logic               cfg_valid;
  logic               cfg_ready_o;
  logic               cfg_data;

  xlate_scoreboard sb;
  int          idle_pct;
  int          stall_pct;
  int          sent;
  logic [7:0]  pattern_q[$];

  posix_regex_to_ecma_translator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_stall = ($urandom_range(99) < stall_pct);
  end

  // Outputs first: a byte accepted at this edge cannot leave before the next one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall) sb.check_result(out_data_o);
      if (in_valid && !in_stall_o) sb.note_input(in_data);
    end
  end

  // Entered and left at a falling edge.
  task automatic send_byte(logic [7:0] c, logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_data.pattern_char = c;
    in_data.pattern_last = last;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
    @(negedge clk_i);
    in_valid = 1'b0;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic wait_drain();
    int guard;
    guard = 0;
    while (sb.expected_q.size() != 0 && guard < 20000) begin
      @(negedge clk_i);
      guard++;
    end
    // an escape byte yields nothing, so allow the pipe to settle
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_mode(logic m);
    wait_drain();
    cfg_valid = 1'b1;
    cfg_data = m;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.extended = m;
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [7:0] any_byte();
    string specials;
    specials = "\\[]^:.=(){}+?|<>b";
    if ($urandom_range(1)) return 8'($urandom_range(255));
    return specials[$urandom_range(specials.len() - 1)];
  endfunction

  // Mostly well-formed tokens; some patterns are cut short to leave brackets open.
  task automatic fill_pattern();
    string groups;
    string kinds;
    int    target;
    int    roll;
    logic [7:0] k;
    groups = "(){}+?|";
    kinds = ":.=";
    pattern_q.delete();
    target = $urandom_range(1, 14);
    while (pattern_q.size() < target) begin
      roll = $urandom_range(99);
      if (roll < 25) begin
        pattern_q.push_back(any_byte());
      end else if (roll < 40) begin
        pattern_q.push_back(groups[$urandom_range(groups.len() - 1)]);
      end else if (roll < 60) begin
        pattern_q.push_back(prx_pkg::CharBslash);
        pattern_q.push_back(any_byte());
      end else begin
        pattern_q.push_back(prx_pkg::CharLbrack);
        if ($urandom_range(1)) pattern_q.push_back(prx_pkg::CharCaret);
        if ($urandom_range(2) == 0) pattern_q.push_back(prx_pkg::CharRbrack);
        repeat ($urandom_range(3)) begin
          if ($urandom_range(1)) begin
            k = kinds[$urandom_range(2)];
            pattern_q.push_back(prx_pkg::CharLbrack);
            pattern_q.push_back(k);
            repeat ($urandom_range(2)) pattern_q.push_back(any_byte());
            repeat ($urandom_range(1, 2)) pattern_q.push_back(k);
            pattern_q.push_back(prx_pkg::CharRbrack);
          end else begin
            pattern_q.push_back(any_byte());
          end
        end
        pattern_q.push_back(prx_pkg::CharRbrack);
      end
    end
    if ($urandom_range(3) == 0)
      while (pattern_q.size() > target) void'(pattern_q.pop_back());
  endtask

  initial begin
    int quota;
    sb = new();
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    sent = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // basic syntax straight out of reset, then extended syntax
    send_text("\\(\\<(");
    send_text("[^][=a==]]");
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_text("\\");
    send_text("[[.");
    write_mode(1'b1);
    send_text("\\(+\\>");

    for (int ph = 0; ph < 8; ph++) begin
      write_mode(ph[0]);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      // phases may end mid-pattern, so the mode also flips with the scanner busy
      quota = sent + PhaseBytes;
      while (sent < quota) begin
        fill_pattern();
        foreach (pattern_q[i])
          if (sent < quota) send_byte(pattern_q[i], i == pattern_q.size() - 1);
      end
    end

    wait_drain();
    if (sb.expected_q.size() != 0) begin
      $display("%0d translated bytes never came out", sb.expected_q.size());
      sb.errors++;
    end
    $display("%0d pattern bytes sent, %0d translated bytes checked, both syntax modes",
             sent, sb.checked);
    if (sb.errors == 0) begin
      $display("posix_regex_to_ecma_translator_unit_tb: done, clean");
    end else begin
      $display("%0d errors", sb.errors);
      $display("posix_regex_to_ecma_translator_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timeout");
    $display("posix_regex_to_ecma_translator_unit_tb: done, errors");
    $finish;
  end

endmodule
`default_nettype wire
